### rtl/nmea_rmc_field_parser_top_macros.svh
// Assertion macros shared by the parser RTL.
`ifndef NMEA_RMC_FIELD_PARSER_TOP_MACROS_SVH
`define NMEA_RMC_FIELD_PARSER_TOP_MACROS_SVH

`ifndef ASSERT_OFF
// Condition must hold on every edge outside reset.
`define NRMC_ASSERT(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);
// Antecedent in a cycle implies consequent in the same cycle.
`define NRMC_ASSERT_IMP(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error(msg);
// Antecedent in a cycle implies consequent in the next cycle.
`define NRMC_ASSERT_NXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);
`else
`define NRMC_ASSERT(lbl, cond, msg)
`define NRMC_ASSERT_IMP(lbl, pre, post, msg)
`define NRMC_ASSERT_NXT(lbl, pre, post, msg)
`endif

`endif

### rtl/nrmc_pkg.sv
// Shared types, codes and tables of the RMC field parser.
package nrmc_pkg;

  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_A     = 8'h41;
  localparam logic [7:0] CH_V     = 8'h56;

  localparam logic [2:0] FIELD_HDR    = 3'd0;
  localparam logic [2:0] FIELD_TIME   = 3'd1;
  localparam logic [2:0] FIELD_STATUS = 3'd2;
  localparam logic [2:0] FIELD_LAT    = 3'd3;
  localparam logic [2:0] FIELD_NS     = 3'd4;
  localparam logic [2:0] FIELD_LON    = 3'd5;
  localparam logic [2:0] FIELD_EW     = 3'd6;
  localparam logic [2:0] FIELD_DONE   = 3'd7;

  localparam int QDEPTH = 4;
  localparam int OUT_W  = 112;

  localparam logic [33:0] DEG_SCALE = 34'd10000000;
  localparam logic [31:0] RECIP_15  = 32'h11111111;

  typedef struct packed {
    logic [7:0] ch;
    logic       start;
    logic       is_digit;
    logic [3:0] digit;
    logic       is_comma;
    logic       is_dot;
  } item_t;

  typedef struct packed {
    logic        busy;
    logic        valid;
    logic        lon;
    logic [33:0] value;
  } conv_stat_t;

  function automatic longint unsigned pow10(input int n);
    longint unsigned r;
    r = 1;
    for (int i = 0; i < n; i++) begin
      r = r * 10;
    end
    return r;
  endfunction

  function automatic logic [23:0] p10_tab(input logic [2:0] n);
    logic [23:0] r;
    case (n)
      3'd1:    r = 24'd10;
      3'd2:    r = 24'd100;
      3'd3:    r = 24'd1000;
      3'd4:    r = 24'd10000;
      3'd5:    r = 24'd100000;
      3'd6:    r = 24'd1000000;
      3'd7:    r = 24'd10000000;
      default: r = 24'd1;
    endcase
    return r;
  endfunction

endpackage

### rtl/nrmc_front.sv
// Front end: byte intake, character classification and the beat queue.
module nrmc_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           s_axis_tvalid_i,
  output logic           s_axis_tready_o,
  input  logic [7:0]     s_axis_tdata_i,   // char_in[7:0]
  input  logic           s_axis_tuser_i,   // start_of_sentence
  output logic           q_valid_o,
  output nrmc_pkg::item_t q_item_o,
  input  logic           q_pop_i
);

  localparam int PTR_W = $clog2(nrmc_pkg::QDEPTH);
  localparam int CNT_W = $clog2(nrmc_pkg::QDEPTH + 1);

  nrmc_pkg::item_t mem_q [nrmc_pkg::QDEPTH];
  nrmc_pkg::item_t cls;
  logic [PTR_W-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic push;

  always_comb begin
    cls.ch       = s_axis_tdata_i;
    cls.start    = s_axis_tuser_i;
    cls.is_digit = s_axis_tdata_i inside {[nrmc_pkg::CH_ZERO:nrmc_pkg::CH_NINE]};
    cls.digit    = s_axis_tdata_i[3:0];
    cls.is_comma = (s_axis_tdata_i == nrmc_pkg::CH_COMMA);
    cls.is_dot   = (s_axis_tdata_i == nrmc_pkg::CH_DOT);
  end

  assign s_axis_tready_o = (cnt_q != CNT_W'(nrmc_pkg::QDEPTH));
  assign push            = s_axis_tvalid_i && s_axis_tready_o;
  assign q_valid_o       = (cnt_q != '0);
  assign q_item_o        = mem_q[rd_q];

  always_comb begin
    wr_d  = push ? PTR_W'(wr_q + 1'b1) : wr_q;
    rd_d  = q_pop_i ? PTR_W'(rd_q + 1'b1) : rd_q;
    cnt_d = cnt_q;
    if (push && !q_pop_i) begin
      cnt_d = CNT_W'(cnt_q + 1'b1);
    end else if (!push && q_pop_i) begin
      cnt_d = CNT_W'(cnt_q - 1'b1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= cls;
    end
  end

endmodule

### rtl/nrmc_conv.sv
// Coordinate conversion pipeline: degrees and minutes to degrees times 1e7.
module nrmc_conv #(
  parameter int FRACTION_DIGITS = 4,
  localparam int MIN_W = $clog2(nrmc_pkg::pow10(FRACTION_DIGITS + 2)),
  localparam int FC_W  = $clog2(FRACTION_DIGITS + 2)
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 flush_i,
  input  logic                 req_valid_i,
  input  logic [9:0]           req_deg_i,
  input  logic [MIN_W-1:0]     req_min_i,
  input  logic [FC_W-1:0]      req_fd_i,
  input  logic                 req_lon_i,
  output nrmc_pkg::conv_stat_t stat_o
);

  logic [MIN_W+23:0] prod1;
  logic [2:0]        exp_idx;
  logic [59:0]       prod2;
  logic [31:0]       rem_full;
  logic [33:0]       sum4;

  logic        v1_q, v2_q, v3_q, v4_q;
  logic        l1_q, l2_q, l3_q, l4_q;
  logic [29:0] t1_q;
  logic [33:0] dg1_q, dg2_q, dg3_q;
  logic [27:0] u2_q, q2_q, q3_q;
  logic [4:0]  r3_q;
  logic [33:0] res4_q;

  // minutes scaled to 1e-7 minute, always below 1e9
  assign exp_idx  = 3'(3'd7 - 3'(req_fd_i));
  assign prod1    = req_min_i * nrmc_pkg::p10_tab(exp_idx);
  // t/60 = (t/4)/15, reciprocal estimate is exact or one low
  assign prod2    = t1_q[29:2] * nrmc_pkg::RECIP_15;
  assign rem_full = {4'b0, u2_q} - ({q2_q, 4'b0} - {4'b0, q2_q});
  assign sum4     = dg3_q + {6'b0, q3_q} + {33'b0, (r3_q >= 5'd15)};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      v1_q <= req_valid_i && !flush_i;
      v2_q <= v1_q && !flush_i;
      v3_q <= v2_q && !flush_i;
      v4_q <= v3_q && !flush_i;
    end
  end

  always_ff @(posedge clk_i) begin
    t1_q   <= prod1[29:0];
    dg1_q  <= {24'b0, req_deg_i} * nrmc_pkg::DEG_SCALE;
    l1_q   <= req_lon_i;
    u2_q   <= t1_q[29:2];
    q2_q   <= prod2[59:32];
    dg2_q  <= dg1_q;
    l2_q   <= l1_q;
    q3_q   <= q2_q;
    r3_q   <= rem_full[4:0];
    dg3_q  <= dg2_q;
    l3_q   <= l2_q;
    res4_q <= l3_q ? sum4 : {4'b0, sum4[29:0]};
    l4_q   <= l3_q;
  end

  assign stat_o.busy  = v1_q || v2_q || v3_q || v4_q;
  assign stat_o.valid = v4_q;
  assign stat_o.lon   = l4_q;
  assign stat_o.value = res4_q;

endmodule

### rtl/nrmc_back.sv
// Back end: per-field sentence state, hold registers and the result register.
module nrmc_back #(
  parameter int FRACTION_DIGITS = 4,
  localparam int MIN_W = $clog2(nrmc_pkg::pow10(FRACTION_DIGITS + 2)),
  localparam int FC_W  = $clog2(FRACTION_DIGITS + 2)
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       q_valid_i,
  input  nrmc_pkg::item_t            q_item_i,
  output logic                       q_pop_o,
  output logic                       flush_o,
  output logic                       req_valid_o,
  output logic [9:0]                 req_deg_o,
  output logic [MIN_W-1:0]           req_min_o,
  output logic [FC_W-1:0]            req_fd_o,
  output logic                       req_lon_o,
  input  nrmc_pkg::conv_stat_t       conv_i,
  output logic                       m_axis_tvalid_o,
  input  logic                       m_axis_tready_i,
  output logic [nrmc_pkg::OUT_W-1:0] m_axis_tdata_o
);

  logic [2:0]       fld_q, fld_d, fld_e;
  logic [3:0]       pos_q, pos_d, pos_e;
  logic             fix_q, fix_d;
  logic [6:0]       hh_q, hh_d, hh_e, mm_q, mm_d, mm_e, ss_q, ss_d, ss_e;
  logic [9:0]       ms_q, ms_d, ms_e;
  logic [9:0]       deg_q, deg_d, deg_e;
  logic [MIN_W-1:0] min_q, min_d, min_e;
  logic [FC_W-1:0]  fc_q, fc_d, fc_e;
  logic [29:0]      lat_q, lat_d;
  logic [33:0]      lon_q, lon_d;
  logic [7:0]       ns_q, ns_d, ew_q, ew_d;
  logic             ov_q, ov_d;
  logic [nrmc_pkg::OUT_W-1:0] od_q, od_d;
  logic [3:0]       dd, dig;
  logic [3:0]       pos_inc;
  logic             emit_now, emit;
  logic             clr;

  assign clr     = q_item_i.start;
  assign fld_e   = clr ? nrmc_pkg::FIELD_HDR : fld_q;
  assign pos_e   = clr ? 4'd0 : pos_q;
  assign hh_e    = clr ? 7'd0 : hh_q;
  assign mm_e    = clr ? 7'd0 : mm_q;
  assign ss_e    = clr ? 7'd0 : ss_q;
  assign ms_e    = clr ? 10'd0 : ms_q;
  assign deg_e   = clr ? 10'd0 : deg_q;
  assign min_e   = clr ? '0 : min_q;
  assign fc_e    = clr ? '0 : fc_q;
  assign dig     = q_item_i.digit;
  assign pos_inc = (pos_e != 4'hF) ? 4'(pos_e + 4'd1) : pos_e;
  assign dd      = (fld_e == nrmc_pkg::FIELD_LON) ? 4'd3 : 4'd2;

  assign emit_now = q_valid_i && q_item_i.is_comma && (fld_e == nrmc_pkg::FIELD_EW);
  assign q_pop_o  = q_valid_i &&
                    !(emit_now && (conv_i.busy || (ov_q && !m_axis_tready_i)));
  assign emit     = q_pop_o && emit_now;
  assign flush_o  = q_pop_o && clr;

  assign req_valid_o = q_pop_o && q_item_i.is_comma &&
                       (fld_e == nrmc_pkg::FIELD_LAT || fld_e == nrmc_pkg::FIELD_LON);
  assign req_deg_o   = deg_e;
  assign req_min_o   = min_e;
  assign req_fd_o    = (fc_e == '0) ? '0 : FC_W'(fc_e - 1'b1);
  assign req_lon_o   = (fld_e == nrmc_pkg::FIELD_LON);

  always_comb begin
    fld_d = fld_q;
    pos_d = pos_q;
    fix_d = fix_q;
    hh_d  = hh_q;
    mm_d  = mm_q;
    ss_d  = ss_q;
    ms_d  = ms_q;
    deg_d = deg_q;
    min_d = min_q;
    fc_d  = fc_q;
    lat_d = lat_q;
    lon_d = lon_q;
    ns_d  = ns_q;
    ew_d  = ew_q;
    if (conv_i.valid) begin
      if (conv_i.lon) begin
        lon_d = conv_i.value;
      end else begin
        lat_d = conv_i.value[29:0];
      end
    end
    if (q_pop_o) begin
      fld_d = fld_e;
      pos_d = pos_e;
      hh_d  = hh_e;
      mm_d  = mm_e;
      ss_d  = ss_e;
      ms_d  = ms_e;
      deg_d = deg_e;
      min_d = min_e;
      fc_d  = fc_e;
      if (clr) begin
        lat_d = '0;
        lon_d = '0;
        ns_d  = '0;
        ew_d  = '0;
      end
      if (fld_e != nrmc_pkg::FIELD_DONE) begin
        if (q_item_i.is_comma) begin
          fld_d = 3'(fld_e + 3'd1);
          pos_d = '0;
          fc_d  = '0;
          deg_d = '0;
          min_d = '0;
        end else begin
          case (fld_e)
            nrmc_pkg::FIELD_TIME: begin
              if (q_item_i.is_digit) begin
                if (pos_e < 4'd2) begin
                  hh_d = 7'({4'b0, hh_e} * 11'd10 + 11'(dig));
                end else if (pos_e < 4'd4) begin
                  mm_d = 7'({4'b0, mm_e} * 11'd10 + 11'(dig));
                end else if (pos_e < 4'd6) begin
                  ss_d = 7'({4'b0, ss_e} * 11'd10 + 11'(dig));
                end else if (pos_e >= 4'd7 && pos_e <= 4'd9) begin
                  ms_d = 10'({4'b0, ms_e} * 14'd10 + 14'(dig));
                end
              end
              pos_d = pos_inc;
            end
            nrmc_pkg::FIELD_STATUS: begin
              if (pos_e == 4'd0) begin
                if (q_item_i.ch == nrmc_pkg::CH_A) begin
                  fix_d = 1'b1;
                end else if (q_item_i.ch == nrmc_pkg::CH_V) begin
                  fix_d = 1'b0;
                end
              end
              pos_d = pos_inc;
            end
            nrmc_pkg::FIELD_LAT, nrmc_pkg::FIELD_LON: begin
              if (q_item_i.is_digit) begin
                if (fc_e == '0) begin
                  if (pos_e < dd) begin
                    deg_d = 10'({4'b0, deg_e} * 14'd10 + 14'(dig));
                  end else if (pos_e < 4'(dd + 4'd2)) begin
                    min_d = MIN_W'(min_e * MIN_W'(10) + MIN_W'(dig));
                  end
                  pos_d = pos_inc;
                end else if (int'(fc_e) <= FRACTION_DIGITS) begin
                  min_d = MIN_W'(min_e * MIN_W'(10) + MIN_W'(dig));
                  fc_d  = FC_W'(fc_e + 1'b1);
                end
              end else if (q_item_i.is_dot && fc_e == '0) begin
                fc_d = FC_W'(1);
              end
            end
            nrmc_pkg::FIELD_NS: begin
              if (pos_e == 4'd0) begin
                ns_d = q_item_i.ch;
              end
              pos_d = pos_inc;
            end
            nrmc_pkg::FIELD_EW: begin
              if (pos_e == 4'd0) begin
                ew_d = q_item_i.ch;
              end
              pos_d = pos_inc;
            end
            default: begin
              pos_d = pos_inc;
            end
          endcase
        end
      end
    end
  end

  always_comb begin
    ov_d = ov_q;
    od_d = od_q;
    if (emit) begin
      ov_d = 1'b1;
      od_d = {ew_q, lon_q, ns_q, lat_q, ms_e, ss_e, mm_e, hh_e, fix_q};
    end else if (m_axis_tready_i) begin
      ov_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fld_q <= '0;
      pos_q <= '0;
      fix_q <= 1'b0;
      hh_q  <= '0;
      mm_q  <= '0;
      ss_q  <= '0;
      ms_q  <= '0;
      deg_q <= '0;
      min_q <= '0;
      fc_q  <= '0;
      lat_q <= '0;
      lon_q <= '0;
      ns_q  <= '0;
      ew_q  <= '0;
      ov_q  <= 1'b0;
    end else begin
      fld_q <= fld_d;
      pos_q <= pos_d;
      fix_q <= fix_d;
      hh_q  <= hh_d;
      mm_q  <= mm_d;
      ss_q  <= ss_d;
      ms_q  <= ms_d;
      deg_q <= deg_d;
      min_q <= min_d;
      fc_q  <= fc_d;
      lat_q <= lat_d;
      lon_q <= lon_d;
      ns_q  <= ns_d;
      ew_q  <= ew_d;
      ov_q  <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    od_q <= od_d;
  end

  assign m_axis_tvalid_o = ov_q;
  assign m_axis_tdata_o  = od_q;

endmodule

### rtl/nmea_rmc_field_parser_top.sv
// Top level of the NMEA RMC field parser.
// Takes one sentence byte per beat (the bytes after the leading dollar) and
// sustains one byte per cycle. Each byte passes through a four-entry queue
// before the field logic takes it; the comma that closes the E/W field puts
// one result into the output register on the next cycle, where it waits for
// the sink while input keeps flowing. Coordinates are converted in a
// four-stage pipeline started by the comma that closes each coordinate
// field; a result whose closing comma arrives while the longitude
// conversion is still in that pipeline waits for it. The queue absorbs most
// of that wait; with an E/W field of at most one byte it fills and the input
// stalls. A second result stalls the input while the first still waits for
// the sink.
// The fix flag and the result register survive a start beat; it clears all else.
`include "nmea_rmc_field_parser_top_macros.svh"

module nmea_rmc_field_parser_top #(
  parameter int FRACTION_DIGITS = 4
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  input  logic [7:0]   s_axis_tdata_i,   // char_in[7:0]
  input  logic         s_axis_tuser_i,   // start_of_sentence
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  // fix_valid[0] utc_hours[7:1] utc_minutes[14:8] utc_seconds[21:15]
  // utc_millis[31:22] latitude_e7[61:32] ns_char[69:62]
  // longitude_e7[103:70] ew_char[111:104]
  output logic [111:0] m_axis_tdata_o
);

  localparam int MIN_W = $clog2(nrmc_pkg::pow10(FRACTION_DIGITS + 2));
  localparam int FC_W  = $clog2(FRACTION_DIGITS + 2);

  logic                 q_valid, q_pop, flush;
  nrmc_pkg::item_t      q_item;
  logic                 req_valid, req_lon;
  logic [9:0]           req_deg;
  logic [MIN_W-1:0]     req_min;
  logic [FC_W-1:0]      req_fd;
  nrmc_pkg::conv_stat_t conv;

  nrmc_front u_front (
    .clk_i,
    .rst_ni,
    .s_axis_tvalid_i,
    .s_axis_tready_o,
    .s_axis_tdata_i,
    .s_axis_tuser_i,
    .q_valid_o (q_valid),
    .q_item_o  (q_item),
    .q_pop_i   (q_pop)
  );

  nrmc_conv #(.FRACTION_DIGITS(FRACTION_DIGITS)) u_conv (
    .clk_i,
    .rst_ni,
    .flush_i     (flush),
    .req_valid_i (req_valid),
    .req_deg_i   (req_deg),
    .req_min_i   (req_min),
    .req_fd_i    (req_fd),
    .req_lon_i   (req_lon),
    .stat_o      (conv)
  );

  nrmc_back #(.FRACTION_DIGITS(FRACTION_DIGITS)) u_back (
    .clk_i,
    .rst_ni,
    .q_valid_i   (q_valid),
    .q_item_i    (q_item),
    .q_pop_o     (q_pop),
    .flush_o     (flush),
    .req_valid_o (req_valid),
    .req_deg_o   (req_deg),
    .req_min_o   (req_min),
    .req_fd_o    (req_fd),
    .req_lon_o   (req_lon),
    .conv_i      (conv),
    .m_axis_tvalid_o,
    .m_axis_tready_i,
    .m_axis_tdata_o
  );

  `NRMC_ASSERT_IMP(a_full_not_empty, !s_axis_tready_o, q_valid, "full queue reports empty")
  `NRMC_ASSERT_IMP(a_result_from_comma, $rose(m_axis_tvalid_o),
                   $past(q_pop && q_item.is_comma), "result without closing comma")
  `NRMC_ASSERT_NXT(a_start_flushes, q_pop && q_item.start, !conv.valid,
                   "stale conversion survived a sentence start")
  `NRMC_ASSERT_NXT(a_hold_result, m_axis_tvalid_o && !m_axis_tready_i,
                   m_axis_tvalid_o && $stable(m_axis_tdata_o), "result beat changed while stalled")

endmodule
